// File: sv/hwm_pkg.sv
// Shared types, constants and helper functions for the heater warmup / HV mode controller.
package hwm_pkg;

  // Width of the heater seconds counters and of the target registers
  localparam int COUNT_BITS = 10;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // 10 ms ticks are summed into 250 ms periods
  localparam int TICK_MS      = 10;
  localparam int PERIOD_MS    = 250;
  localparam int TICKS_PER_PERIOD = PERIOD_MS / TICK_MS;
  localparam int TICK_BITS    = $clog2(TICKS_PER_PERIOD);
  localparam logic [TICK_BITS-1:0] TICK_LAST = TICK_BITS'(TICKS_PER_PERIOD - 1);

  // Saturation headroom above the target and the heater-off decrement
  localparam int SAT_MARGIN = 3;
  localparam int OFF_DROP   = 2;

  // Reset value of every target register
  localparam logic [COUNT_BITS-1:0] TARGET_RESET = COUNT_BITS'(120);

  // Input word layout
  localparam int IN_W = 8;
  localparam int IN_TICK        = 0;
  localparam int IN_FAULT       = 1;
  localparam int IN_HEATER_FLT  = 2;
  localparam int IN_HV_REQUEST  = 3;
  localparam int IN_READY_OK    = 4;
  localparam int IN_MAG_ON      = 5;
  localparam int IN_GUN_ON      = 6;

  // Result word: mode(3) warm_done(1) thyratron(10) magnetron(10) gun(10), padded to bytes
  localparam int MODE_W  = 3;
  localparam int OUT_RAW = MODE_W + 1 + 3 * COUNT_BITS;
  localparam int OUT_W   = ((OUT_RAW + 7) / 8) * 8;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_THYRATRON = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAGNETRON = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GUN       = 2'd2;

  // Round-robin stages
  localparam logic [1:0] STAGE_READ      = 2'd0;
  localparam logic [1:0] STAGE_THYRATRON = 2'd1;
  localparam logic [1:0] STAGE_MAGNETRON = 2'd2;
  localparam logic [1:0] STAGE_GUN       = 2'd3;

  // Mode codes as they appear on the result word
  localparam logic [MODE_W-1:0] MODE_CODE_STARTUP    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_CODE_WARMUP     = 3'd1;
  localparam logic [MODE_W-1:0] MODE_CODE_STANDBY    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_CODE_DRIVE_UP   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CODE_READY      = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CODE_COLD_FAULT = 3'd5;
  localparam logic [MODE_W-1:0] MODE_CODE_WARM_FAULT = 3'd6;

  // Mode machine states, one-hot
  typedef enum logic [6:0] {
    MS_STARTUP    = 7'b0000001,
    MS_WARMUP     = 7'b0000010,
    MS_STANDBY    = 7'b0000100,
    MS_DRIVE_UP   = 7'b0001000,
    MS_READY      = 7'b0010000,
    MS_COLD_FAULT = 7'b0100000,
    MS_WARM_FAULT = 7'b1000000
  } hwm_mode_t;

  // Control from the mode machine to the heater timers
  typedef struct packed {
    logic run;    // timers run this poll
    logic clear;  // entering warmup: clear counters and done flag
  } hwm_ctrl_t;

  // Map a state to its result code
  function automatic logic [MODE_W-1:0] mode_code(input hwm_mode_t m);
    logic [MODE_W-1:0] c;
    case (m)
      MS_STARTUP:    c = MODE_CODE_STARTUP;
      MS_WARMUP:     c = MODE_CODE_WARMUP;
      MS_STANDBY:    c = MODE_CODE_STANDBY;
      MS_DRIVE_UP:   c = MODE_CODE_DRIVE_UP;
      MS_READY:      c = MODE_CODE_READY;
      MS_COLD_FAULT: c = MODE_CODE_COLD_FAULT;
      MS_WARM_FAULT: c = MODE_CODE_WARM_FAULT;
      default:       c = MODE_CODE_COLD_FAULT;
    endcase
    return c;
  endfunction

  // One-second step of a heater counter: saturating increment, or drop while off
  function automatic logic [COUNT_BITS-1:0] step_count(
    input logic [COUNT_BITS-1:0] count,
    input logic [COUNT_BITS-1:0] target,
    input logic                  on
  );
    logic [COUNT_BITS:0]   lim;
    logic [COUNT_BITS:0]   inc;
    logic [COUNT_BITS-1:0] res;
    lim = {1'b0, target} + (COUNT_BITS+1)'(SAT_MARGIN);
    if (lim > {1'b0, COUNT_MAX}) begin
      lim = {1'b0, COUNT_MAX};
    end
    inc = {1'b0, count} + (COUNT_BITS+1)'(1);
    if (on) begin
      if (inc >= lim) begin
        inc = lim;
      end
      res = inc[COUNT_BITS-1:0];
    end else if (count >= COUNT_BITS'(OFF_DROP)) begin
      res = count - COUNT_BITS'(OFF_DROP);
    end else begin
      res = count;
    end
    return res;
  endfunction

endpackage

// File: sv/hwm_cfg.sv
// Target-seconds configuration registers.
module hwm_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [hwm_pkg::CFG_IDX_W-1:0]      wr_index,
  input  logic [hwm_pkg::COUNT_BITS-1:0]     wr_data,
  output logic [hwm_pkg::COUNT_BITS-1:0]     thy_target,
  output logic [hwm_pkg::COUNT_BITS-1:0]     mag_target,
  output logic [hwm_pkg::COUNT_BITS-1:0]     gun_target
);

  logic [hwm_pkg::COUNT_BITS-1:0] thy_target_r;
  logic [hwm_pkg::COUNT_BITS-1:0] mag_target_r;
  logic [hwm_pkg::COUNT_BITS-1:0] gun_target_r;

  // Write the addressed target; drop writes beyond the list
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thy_target_r <= hwm_pkg::TARGET_RESET;
      mag_target_r <= hwm_pkg::TARGET_RESET;
      gun_target_r <= hwm_pkg::TARGET_RESET;
    end else if (wr_en) begin
      case (wr_index)
        hwm_pkg::CFG_THYRATRON: thy_target_r <= wr_data;
        hwm_pkg::CFG_MAGNETRON: mag_target_r <= wr_data;
        hwm_pkg::CFG_GUN:       gun_target_r <= wr_data;
        default: ;
      endcase
    end
  end

  assign thy_target = thy_target_r;
  assign mag_target = mag_target_r;
  assign gun_target = gun_target_r;

endmodule

// File: sv/hwm_heat.sv
// Tick prescaler, round robin and the three heater warmup counters.
module hwm_heat (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           step_en,
  input  hwm_pkg::hwm_ctrl_t             ctrl,
  input  logic                           tick,
  input  logic                           mag_on,
  input  logic                           gun_on,
  input  logic [hwm_pkg::COUNT_BITS-1:0] thy_target,
  input  logic [hwm_pkg::COUNT_BITS-1:0] mag_target,
  input  logic [hwm_pkg::COUNT_BITS-1:0] gun_target,
  output logic [hwm_pkg::COUNT_BITS-1:0] thy_nxt,
  output logic [hwm_pkg::COUNT_BITS-1:0] mag_nxt,
  output logic [hwm_pkg::COUNT_BITS-1:0] gun_nxt,
  output logic                           done_nxt
);

  logic [hwm_pkg::TICK_BITS-1:0]  tick_cnt_r, tick_cnt_nxt;
  logic [1:0]                     stage_r, stage_nxt;
  logic [hwm_pkg::COUNT_BITS-1:0] thy_r, mag_r, gun_r;
  logic                           done_r;

  // Next state for one poll
  always_comb begin
    tick_cnt_nxt = tick_cnt_r;
    stage_nxt    = stage_r;
    thy_nxt      = thy_r;
    mag_nxt      = mag_r;
    gun_nxt      = gun_r;
    done_nxt     = done_r;
    if (ctrl.clear) begin
      thy_nxt  = '0;
      mag_nxt  = '0;
      gun_nxt  = '0;
      done_nxt = 1'b0;
    end else if (ctrl.run && tick) begin
      if (tick_cnt_r == hwm_pkg::TICK_LAST) begin
        // 250 ms elapsed: advance the round robin one stage
        tick_cnt_nxt = '0;
        stage_nxt    = stage_r + 2'd1;
        case (stage_r)
          hwm_pkg::STAGE_THYRATRON: thy_nxt = hwm_pkg::step_count(thy_r, thy_target, 1'b1);
          hwm_pkg::STAGE_MAGNETRON: mag_nxt = hwm_pkg::step_count(mag_r, mag_target, mag_on);
          hwm_pkg::STAGE_GUN:       gun_nxt = hwm_pkg::step_count(gun_r, gun_target, gun_on);
          default: ;
        endcase
        done_nxt = (thy_nxt >= thy_target) && (mag_nxt >= mag_target) &&
                   (gun_nxt >= gun_target);
      end else begin
        tick_cnt_nxt = tick_cnt_r + hwm_pkg::TICK_BITS'(1);
      end
    end
  end

  // Commit on each accepted poll
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_cnt_r <= '0;
      stage_r    <= hwm_pkg::STAGE_READ;
      thy_r      <= '0;
      mag_r      <= '0;
      gun_r      <= '0;
      done_r     <= 1'b0;
    end else if (step_en) begin
      tick_cnt_r <= tick_cnt_nxt;
      stage_r    <= stage_nxt;
      thy_r      <= thy_nxt;
      mag_r      <= mag_nxt;
      gun_r      <= gun_nxt;
      done_r     <= done_nxt;
    end
  end

  a_clear_zeroes: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && ctrl.clear) |=> (thy_r == '0 && mag_r == '0 && gun_r == '0 && !done_r))
    else $error("counters not cleared on warmup entry");

  a_tick_range: assert property (@(posedge clk) disable iff (!rst_n)
    tick_cnt_r <= hwm_pkg::TICK_LAST)
    else $error("tick prescaler out of range");

  a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !step_en |=> ($stable(stage_r) && $stable(thy_r) && $stable(mag_r) && $stable(gun_r)))
    else $error("heater state moved without a poll");

endmodule

// File: sv/hwm_mode.sv
// High-voltage mode machine with fault priority.
module hwm_mode (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step_en,
  input  logic                       fault,
  input  logic                       heater_fault,
  input  logic                       hv_request,
  input  logic                       ready_ok,
  input  logic                       done_nxt,
  output hwm_pkg::hwm_ctrl_t         ctrl,
  output logic [hwm_pkg::MODE_W-1:0] mode_code_nxt
);

  hwm_pkg::hwm_mode_t mode_r, mode_nxt;

  // Timer control depends only on the current mode and the fault bit
  always_comb begin
    ctrl.run   = (mode_r == hwm_pkg::MS_WARMUP)   || (mode_r == hwm_pkg::MS_STANDBY) ||
                 (mode_r == hwm_pkg::MS_DRIVE_UP) || (mode_r == hwm_pkg::MS_READY);
    ctrl.clear = (mode_r == hwm_pkg::MS_STARTUP) ||
                 ((mode_r == hwm_pkg::MS_COLD_FAULT) && !fault);
  end

  // Transitions; in warmup, standby, drive-up and ready a fault wins over everything else
  always_comb begin
    mode_nxt = mode_r;
    case (mode_r)
      hwm_pkg::MS_STARTUP: mode_nxt = hwm_pkg::MS_WARMUP;
      hwm_pkg::MS_WARMUP: begin
        if (fault)         mode_nxt = hwm_pkg::MS_COLD_FAULT;
        else if (done_nxt) mode_nxt = hwm_pkg::MS_STANDBY;
      end
      hwm_pkg::MS_STANDBY: begin
        if (fault)           mode_nxt = hwm_pkg::MS_WARM_FAULT;
        else if (hv_request) mode_nxt = hwm_pkg::MS_DRIVE_UP;
      end
      hwm_pkg::MS_DRIVE_UP: begin
        if (fault)            mode_nxt = hwm_pkg::MS_WARM_FAULT;
        else if (!hv_request) mode_nxt = hwm_pkg::MS_STANDBY;
        else if (ready_ok)    mode_nxt = hwm_pkg::MS_READY;
      end
      hwm_pkg::MS_READY: begin
        if (fault)            mode_nxt = hwm_pkg::MS_WARM_FAULT;
        else if (!hv_request) mode_nxt = hwm_pkg::MS_STANDBY;
      end
      hwm_pkg::MS_WARM_FAULT: begin
        if (heater_fault) mode_nxt = hwm_pkg::MS_COLD_FAULT;
        else if (!fault)  mode_nxt = hwm_pkg::MS_STANDBY;
      end
      hwm_pkg::MS_COLD_FAULT: begin
        if (!fault) mode_nxt = hwm_pkg::MS_WARMUP;
      end
      default: mode_nxt = hwm_pkg::MS_COLD_FAULT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= hwm_pkg::MS_STARTUP;
    end else if (step_en) begin
      mode_r <= mode_nxt;
    end
  end

  assign mode_code_nxt = hwm_pkg::mode_code(mode_nxt);

  a_heater_fault_cold: assert property (@(posedge clk) disable iff (!rst_n)
    (step_en && mode_r == hwm_pkg::MS_WARM_FAULT && heater_fault)
      |=> (mode_r == hwm_pkg::MS_COLD_FAULT))
    else $error("heater fault did not force cold fault");

endmodule

// File: sv/heater_warmup_and_hv_mode_control.sv
// Top level: input register, mode machine, heater timers and result register.
// Path: a poll word accepted into the input register is stepped through the mode machine and
//   heater timers when the result register can load; its result word is then held there for out_tdata.
// Throughput: one word per cycle; on a stalled result one more word is held, then in_tready drops.
// Reset (rst_n, synchronous, active low): mode startup, counters, done flag,
//   prescaler and round robin cleared, all three targets 120 s, no word held.
module heater_warmup_and_hv_mode_control (
  input  logic                          clk,
  input  logic                          rst_n,
  // in_tdata: [0] tick, [1] fault, [2] heater_fault, [3] hv_request, [4] ready_ok,
  //           [5] magnetron_heater_on, [6] gun_heater_on, [7] zero
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [hwm_pkg::IN_W-1:0]      in_tdata,
  // out_tdata: [2:0] mode, [3] warm_done, [13:4] thyratron_seconds,
  //            [23:14] magnetron_seconds, [33:24] gun_seconds, [39:34] zero
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [hwm_pkg::OUT_W-1:0]     out_tdata,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [hwm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hwm_pkg::COUNT_BITS-1:0] cfg_data
);

  logic                           s1_valid_r;
  logic [hwm_pkg::IN_W-1:0]       s1_word_r;
  logic                           s1_go;
  logic                           out_valid_r;
  logic [hwm_pkg::OUT_W-1:0]      out_word_r;
  logic [hwm_pkg::COUNT_BITS-1:0] thy_target, mag_target, gun_target;
  logic [hwm_pkg::COUNT_BITS-1:0] thy_nxt, mag_nxt, gun_nxt;
  logic                           done_nxt;
  logic [hwm_pkg::MODE_W-1:0]     mode_code_nxt;
  hwm_pkg::hwm_ctrl_t             ctrl;

  // Handshake: the input register drains whenever the result register can load
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_go;
  assign cfg_ready = 1'b1;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_word_r <= in_tdata;
    end
  end

  hwm_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .wr_en      (cfg_valid && cfg_ready),
    .wr_index   (cfg_index),
    .wr_data    (cfg_data),
    .thy_target (thy_target),
    .mag_target (mag_target),
    .gun_target (gun_target)
  );

  hwm_mode u_mode (
    .clk           (clk),
    .rst_n         (rst_n),
    .step_en       (s1_go),
    .fault         (s1_word_r[hwm_pkg::IN_FAULT]),
    .heater_fault  (s1_word_r[hwm_pkg::IN_HEATER_FLT]),
    .hv_request    (s1_word_r[hwm_pkg::IN_HV_REQUEST]),
    .ready_ok      (s1_word_r[hwm_pkg::IN_READY_OK]),
    .done_nxt      (done_nxt),
    .ctrl          (ctrl),
    .mode_code_nxt (mode_code_nxt)
  );

  hwm_heat u_heat (
    .clk        (clk),
    .rst_n      (rst_n),
    .step_en    (s1_go),
    .ctrl       (ctrl),
    .tick       (s1_word_r[hwm_pkg::IN_TICK]),
    .mag_on     (s1_word_r[hwm_pkg::IN_MAG_ON]),
    .gun_on     (s1_word_r[hwm_pkg::IN_GUN_ON]),
    .thy_target (thy_target),
    .mag_target (mag_target),
    .gun_target (gun_target),
    .thy_nxt    (thy_nxt),
    .mag_nxt    (mag_nxt),
    .gun_nxt    (gun_nxt),
    .done_nxt   (done_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_word_r <= {(hwm_pkg::OUT_W - hwm_pkg::OUT_RAW)'(0),
                     gun_nxt, mag_nxt, thy_nxt, done_nxt, mode_code_nxt};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_word_r;

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready && s1_valid_r) |-> !in_tready)
    else $error("input register overrun while result stalled");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_go |=> out_valid_r)
    else $error("advanced poll produced no result");

endmodule
